/* rtl/core/vdes_pkg.sv */
// Shared types, codes and helper functions of the display event sequencer.
package vdes_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int SLOT_COUNT      = 8;

  localparam logic [1:0] MODE_ENQ   = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;
  localparam logic [1:0] MODE_HURRY = 2'd3;

  localparam logic [2:0] KIND_STOP = 3'd0;
  localparam logic [2:0] KIND_WAIT = 3'd1;
  localparam logic [2:0] KIND_PAL  = 3'd2;
  localparam logic [2:0] KIND_PAN  = 3'd3;
  localparam logic [2:0] KIND_DONE = 3'd4;

  localparam int MASK_PAL_BIT = 0;
  localparam int MASK_PAN_BIT = 1;

  localparam logic [7:0] FADE_LIMIT = 8'd64;
  localparam logic [8:0] COUNT_MAX  = 9'd256;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] word;
    logic [15:0] pan_end;
    logic [15:0] pan_adjust;
    logic [2:0]  slot;
    logic [7:0]  first;
    logic [8:0]  count;
    logic [7:0]  target;
    logic        fade_on;
    logic [7:0]  fade_value;
    logic [7:0]  fade_step;
  } entry_t;

  typedef struct packed {
    logic        status;
    logic        start_valid;
    logic [15:0] start_address;
    logic        pal_valid;
    logic [2:0]  slot;
    logic [7:0]  first;
    logic [8:0]  count;
    logic [7:0]  target;
    logic        cap_on;
    logic [7:0]  cap_level;
    logic        chain_pulse;
  } res_t;

  typedef struct packed {
    logic load_pal;
    logic load_pan;
    logic run;
  } job_ctl_t;

  function automatic logic [2:0] slot_wrap(logic [2:0] v);
    logic [4:0] r;
    r = {2'b00, v};
    for (int k = 0; k < 8; k++) begin
      if (r >= 5'(SLOT_COUNT)) begin
        r = r - 5'(SLOT_COUNT);
      end
    end
    return r[2:0];
  endfunction

  function automatic logic [8:0] sat_count(logic [8:0] c);
    return (c > COUNT_MAX) ? COUNT_MAX : c;
  endfunction

endpackage

/* rtl/core/vsync_display_event_sequencer.sv */
// Top level of the retrace-driven display event sequencer.
//
// Input channel (in_valid_i / in_stall_o) carries one transaction per command:
// enqueue an event, retrace tick, flush the queue, or hurry the head wait.
// Output channel (out_valid_o / out_stall_i) returns one transaction per
// command with status, display start, palette job descriptor, chain pulse
// and queue_idle. chain_step is written through the APB port at address 0.
// Enqueue and flush go from idle to the response state, which loads the output
// register; hurry first reads the head entry, and a tick first walks the queue,
// one read of the queue RAM's single registered read port per entry, then the jobs.
// One command is in flight at a time; the next transaction is taken once the
// result sits in the output register, even while the receiver stalls it.
// A stalled result holds in the output register; a further finished result
// waits inside the block and in_stall_o stays high until it is moved out.
// Reset clears queue positions, job busy flags and the phase accumulator;
// queue contents are not cleared and need no clearing pass.
module vsync_display_event_sequencer
  import vdes_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [2:0]  event_kind_i,
  input  logic [15:0] first_word_i,
  input  logic [15:0] pan_end_i,
  input  logic [15:0] pan_adjust_i,
  input  logic [2:0]  pal_slot_i,
  input  logic [7:0]  pal_first_i,
  input  logic [8:0]  pal_count_i,
  input  logic [7:0]  pal_target_i,
  input  logic        fade_on_i,
  input  logic [7:0]  fade_value_i,
  input  logic [7:0]  fade_step_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic        start_valid_o,
  output logic [15:0] start_address_o,
  output logic        pal_valid_o,
  output logic [2:0]  out_slot_o,
  output logic [7:0]  out_first_o,
  output logic [8:0]  out_count_o,
  output logic [7:0]  out_target_o,
  output logic        cap_on_o,
  output logic [7:0]  cap_level_o,
  output logic        chain_pulse_o,
  output logic        queue_idle_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int PW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_HURRY = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_JOBS  = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [PW-1:0] rp_q, rp_d, wp_q, wp_d, rp_inc;
  res_t          res_q, res_d, out_q, job_res;
  logic          out_valid_q, idle_q, load_out;
  logic [15:0]   chain_step_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, new_entry, head;
  job_ctl_t      job_ctl;
  logic          pal_busy, pan_busy;
  logic          head_live;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, chain_step_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_step_q <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      chain_step_q <= pwdata[15:0];
    end
  end

  always_comb begin
    new_entry.kind       = event_kind_i;
    new_entry.word       = first_word_i;
    new_entry.pan_end    = pan_end_i;
    new_entry.pan_adjust = pan_adjust_i;
    new_entry.slot       = slot_wrap(pal_slot_i);
    new_entry.first      = pal_first_i;
    new_entry.count      = sat_count(pal_count_i);
    new_entry.target     = pal_target_i;
    new_entry.fade_on    = fade_on_i;
    new_entry.fade_value = fade_value_i;
    new_entry.fade_step  = fade_step_i;
  end

  assign head_live  = rp_q < wp_q;
  assign rp_inc     = rp_q + 1'b1;
  assign in_stall_o = state_q != ST_IDLE;

  always_comb begin
    state_d   = state_q;
    rp_d      = rp_q;
    wp_d      = wp_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = wp_q[AW-1:0];
    mem_wdata = new_entry;
    mem_re    = 1'b0;
    mem_raddr = rp_q[AW-1:0];
    job_ctl   = '0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d = '0;
          unique case (mode_i)
            MODE_ENQ: begin
              if (wp_q == PW'(QUEUE_DEPTH)) begin
                res_d.status = 1'b1;
              end else begin
                mem_we = 1'b1;
                wp_d   = wp_q + 1'b1;
              end
              state_d = ST_RESP;
            end
            MODE_TICK: begin
              mem_re  = head_live;
              state_d = head_live ? ST_WALK : ST_JOBS;
            end
            MODE_FLUSH: begin
              rp_d    = '0;
              wp_d    = '0;
              state_d = ST_RESP;
            end
            MODE_HURRY: begin
              mem_re  = head_live;
              state_d = head_live ? ST_HURRY : ST_RESP;
            end
          endcase
        end
      end
      ST_HURRY: begin
        if (head.kind == KIND_WAIT) begin
          mem_we         = 1'b1;
          mem_waddr      = rp_q[AW-1:0];
          mem_wdata      = head;
          mem_wdata.word = '0;
        end
        state_d = ST_RESP;
      end
      ST_WALK: begin
        state_d = ST_JOBS;
        unique case (head.kind)
          KIND_STOP: begin
            rp_d = '0;
            wp_d = '0;
          end
          KIND_WAIT: begin
            if (head.word == '0) begin
              rp_d = rp_inc;
            end else begin
              mem_we         = 1'b1;
              mem_waddr      = rp_q[AW-1:0];
              mem_wdata      = head;
              mem_wdata.word = head.word - 1'b1;
            end
          end
          KIND_DONE: begin
            if (!((head.word[MASK_PAL_BIT] && pal_busy) ||
                  (head.word[MASK_PAN_BIT] && pan_busy))) begin
              rp_d = rp_inc;
            end
          end
          default: begin
            job_ctl.load_pal = head.kind == KIND_PAL;
            job_ctl.load_pan = head.kind == KIND_PAN;
            rp_d             = rp_inc;
          end
        endcase
        if (head.kind != KIND_STOP && head.kind != KIND_WAIT && rp_d == rp_inc &&
            rp_inc < wp_q) begin
          mem_re    = 1'b1;
          mem_raddr = rp_inc[AW-1:0];
          state_d   = ST_WALK;
        end
      end
      ST_JOBS: begin
        job_ctl.run = 1'b1;
        res_d       = job_res;
        state_d     = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (load_out) begin
      out_q  <= res_q;
      idle_q <= rp_q == wp_q;
    end
  end

  vdes_queue_ram #(
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(head)
  );

  vdes_job_unit u_jobs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (job_ctl),
    .entry_i     (head),
    .chain_step_i(chain_step_q),
    .pal_busy_o  (pal_busy),
    .pan_busy_o  (pan_busy),
    .res_o       (job_res)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign start_valid_o   = out_q.start_valid;
  assign start_address_o = out_q.start_address;
  assign pal_valid_o     = out_q.pal_valid;
  assign out_slot_o      = out_q.slot;
  assign out_first_o     = out_q.first;
  assign out_count_o     = out_q.count;
  assign out_target_o    = out_q.target;
  assign cap_on_o        = out_q.cap_on;
  assign cap_level_o     = out_q.cap_level;
  assign chain_pulse_o   = out_q.chain_pulse;
  assign queue_idle_o    = idle_q;

endmodule

/* rtl/core/vdes_queue_ram.sv */
// Event queue storage: one write port, one registered read port.
module vdes_queue_ram
  import vdes_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/vdes_job_unit.sv */
// Palette and pan jobs plus the chain phase accumulator, stepped once per tick.
module vdes_job_unit
  import vdes_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  job_ctl_t    ctl_i,
  input  entry_t      entry_i,
  input  logic [15:0] chain_step_i,
  output logic        pal_busy_o,
  output logic        pan_busy_o,
  output res_t        res_o
);

  logic        pal_busy_q, pal_busy_d;
  logic        pan_busy_q, pan_busy_d;
  entry_t      pal_job_q, pal_job_d;
  entry_t      pan_job_q, pan_job_d;
  logic [15:0] phase_q, phase_d;
  logic [16:0] phase_sum;
  logic [7:0]  fade_next;
  logic [15:0] pan_next;

  assign fade_next = pal_job_q.fade_value + pal_job_q.fade_step;
  assign pan_next  = pan_job_q.word + pan_job_q.pan_adjust;
  assign phase_sum = {1'b0, phase_q} + {1'b0, chain_step_i};

  always_comb begin
    pal_busy_d = pal_busy_q;
    pan_busy_d = pan_busy_q;
    pal_job_d  = pal_job_q;
    pan_job_d  = pan_job_q;
    phase_d    = phase_q;
    res_o      = '0;
    if (ctl_i.load_pal) begin
      pal_job_d  = entry_i;
      pal_busy_d = 1'b1;
    end
    if (ctl_i.load_pan) begin
      pan_job_d  = entry_i;
      pan_busy_d = 1'b1;
    end
    if (ctl_i.run) begin
      if (pal_busy_q) begin
        res_o.pal_valid = 1'b1;
        res_o.slot      = pal_job_q.slot;
        res_o.first     = pal_job_q.first;
        res_o.count     = pal_job_q.count;
        res_o.target    = pal_job_q.target;
        if (pal_job_q.fade_on) begin
          res_o.cap_on         = 1'b1;
          res_o.cap_level      = pal_job_q.fade_value;
          pal_job_d.fade_value = fade_next;
          if (fade_next > FADE_LIMIT) begin
            pal_busy_d = 1'b0;
          end
        end else begin
          pal_busy_d = 1'b0;
        end
      end
      if (pan_busy_q) begin
        res_o.start_valid   = 1'b1;
        res_o.start_address = pan_job_q.word;
        if (pan_job_q.word != pan_job_q.pan_end) begin
          pan_job_d.word = pan_next;
        end else begin
          pan_busy_d = 1'b0;
        end
      end
      phase_d           = phase_sum[15:0];
      res_o.chain_pulse = phase_sum[16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_busy_q <= 1'b0;
      pan_busy_q <= 1'b0;
      phase_q    <= '0;
    end else begin
      pal_busy_q <= pal_busy_d;
      pan_busy_q <= pan_busy_d;
      phase_q    <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pal_job_q <= pal_job_d;
    pan_job_q <= pan_job_d;
  end

  assign pal_busy_o = pal_busy_q;
  assign pan_busy_o = pan_busy_q;

endmodule

/* rtl/core/vdes_checker.sv */
// Port-level checks of the display event sequencer, bound to the top level.
module vdes_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        status_o,
  input logic        start_valid_o,
  input logic [15:0] start_address_o,
  input logic        pal_valid_o,
  input logic [8:0]  out_count_o,
  input logic        cap_on_o,
  input logic [7:0]  cap_level_o,
  input logic        chain_pulse_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(start_address_o))
    else $error("stalled output transaction changed");

  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !start_valid_o |-> start_address_o == 16'd0)
    else $error("display start set without start_valid");

  a_cap_pal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cap_on_o || cap_level_o != 8'd0) |-> pal_valid_o && cap_on_o)
    else $error("fade cap without palette job");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pal_valid_o |-> out_count_o <= 9'd256)
    else $error("palette count above 256");

  a_drop_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !start_valid_o && !pal_valid_o && !chain_pulse_o)
    else $error("dropped enqueue reported tick activity");

endmodule

bind vsync_display_event_sequencer vdes_checker u_vdes_checker (.*);

/* bench/tb_vsync_display_event_sequencer.sv */
// Self-checking testbench for the retrace-driven display event sequencer.
`timescale 1ns / 100ps

module tb_vsync_display_event_sequencer;
  import vdes_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 172;
  localparam logic [2:0] ADDR_CHAIN_STEP = 3'd0;
  localparam logic [2:0] KIND_BOGUS = 3'd7;

  typedef struct packed {
    logic [1:0] mode;
    entry_t     ev;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic        start_valid;
    logic [15:0] start_address;
    logic        pal_valid;
    logic [2:0]  slot;
    logic [7:0]  first;
    logic [8:0]  count;
    logic [7:0]  target;
    logic        cap_on;
    logic [7:0]  cap_level;
    logic        chain_pulse;
    logic        queue_idle;
  } frame_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = '0;
  logic [2:0]  event_kind_i = '0;
  logic [15:0] first_word_i = '0;
  logic [15:0] pan_end_i = '0;
  logic [15:0] pan_adjust_i = '0;
  logic [2:0]  pal_slot_i = '0;
  logic [7:0]  pal_first_i = '0;
  logic [8:0]  pal_count_i = '0;
  logic [7:0]  pal_target_i = '0;
  logic        fade_on_i = 1'b0;
  logic [7:0]  fade_value_i = '0;
  logic [7:0]  fade_step_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        status_o;
  logic        start_valid_o;
  logic [15:0] start_address_o;
  logic        pal_valid_o;
  logic [2:0]  out_slot_o;
  logic [7:0]  out_first_o;
  logic [8:0]  out_count_o;
  logic [7:0]  out_target_o;
  logic        cap_on_o;
  logic [7:0]  cap_level_o;
  logic        chain_pulse_o;
  logic        queue_idle_o;

  vsync_display_event_sequencer DUT (.*);

  always #2 clk_i = ~clk_i;

  // predicted block state
  entry_t      ev_store [DEPTH];
  int          head_idx = 0;
  int          tail_idx = 0;
  bit          pal_active = 1'b0;
  entry_t      pal_cur = '0;
  bit          pan_active = 1'b0;
  entry_t      pan_cur = '0;
  logic [15:0] phase_sum = '0;
  logic [15:0] step_reg = '0;

  frame_res_t  due_updates [$];
  int          err_count = 0;
  int          xfer_count = 0;
  int          n_ticks = 0;
  int          n_pal = 0;
  int          n_fade = 0;
  int          n_pan = 0;
  int          n_pulse = 0;
  int          n_drop = 0;
  int          n_holds = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          stall_burst = 0;
  int          quiet_cycles = 0;

  function automatic frame_res_t display_update(cmd_t c);
    frame_res_t  r;
    entry_t      e;
    logic [16:0] sum;
    logic [7:0]  lvl;
    bit          walking;
    r = '0;
    case (c.mode)
      MODE_ENQ: begin
        if (tail_idx >= DEPTH) begin
          r.status = 1'b1;
        end else begin
          e = c.ev;
          if (e.count > 9'd256) e.count = 9'd256;
          ev_store[tail_idx] = e;
          tail_idx++;
        end
      end
      MODE_TICK: begin
        walking = 1'b1;
        while (walking && head_idx < tail_idx) begin
          case (ev_store[head_idx].kind)
            KIND_STOP: begin
              head_idx = 0;
              tail_idx = 0;
              walking = 1'b0;
            end
            KIND_WAIT: begin
              if (ev_store[head_idx].word == 16'd0) head_idx++;
              else ev_store[head_idx].word = ev_store[head_idx].word - 16'd1;
              walking = 1'b0;
            end
            KIND_PAL: begin
              pal_cur = ev_store[head_idx];
              pal_active = 1'b1;
              head_idx++;
            end
            KIND_PAN: begin
              pan_cur = ev_store[head_idx];
              pan_active = 1'b1;
              head_idx++;
            end
            KIND_DONE: begin
              if ((ev_store[head_idx].word[MASK_PAL_BIT] && pal_active) ||
                  (ev_store[head_idx].word[MASK_PAN_BIT] && pan_active)) walking = 1'b0;
              else head_idx++;
            end
            default: head_idx++;
          endcase
        end
        if (pal_active) begin
          r.pal_valid = 1'b1;
          r.slot = pal_cur.slot;
          r.first = pal_cur.first;
          r.count = pal_cur.count;
          r.target = pal_cur.target;
          if (pal_cur.fade_on) begin
            r.cap_on = 1'b1;
            r.cap_level = pal_cur.fade_value;
            lvl = pal_cur.fade_value + pal_cur.fade_step;
            pal_cur.fade_value = lvl;
            if (lvl > FADE_LIMIT) pal_active = 1'b0;
          end else begin
            pal_active = 1'b0;
          end
        end
        if (pan_active) begin
          r.start_valid = 1'b1;
          r.start_address = pan_cur.word;
          if (pan_cur.word != pan_cur.pan_end) pan_cur.word = pan_cur.word + pan_cur.pan_adjust;
          else pan_active = 1'b0;
        end
        sum = {1'b0, phase_sum} + {1'b0, step_reg};
        phase_sum = sum[15:0];
        r.chain_pulse = sum[16];
      end
      MODE_FLUSH: begin
        head_idx = 0;
        tail_idx = 0;
      end
      default: begin
        if (head_idx < tail_idx && ev_store[head_idx].kind == KIND_WAIT)
          ev_store[head_idx].word = 16'd0;
      end
    endcase
    r.queue_idle = (head_idx == tail_idx);
    return r;
  endfunction

  function automatic frame_res_t quiet_res(logic idle, logic status);
    frame_res_t r;
    r = '0;
    r.queue_idle = idle;
    r.status = status;
    return r;
  endfunction

  function automatic entry_t make_ev(logic [2:0] kind, logic [15:0] word, logic [15:0] pend,
                                     logic [15:0] padj, logic [2:0] slot, logic [7:0] first,
                                     logic [8:0] count, logic [7:0] target, logic fon,
                                     logic [7:0] fval, logic [7:0] fstep);
    return {kind, word, pend, padj, slot, first, count, target, fon, fval, fstep};
  endfunction

  function automatic cmd_t noise_cmd();
    logic [127:0] raw;
    cmd_t         c;
    raw = {$urandom, $urandom, $urandom, $urandom};
    c = raw[97:0];
    return c;
  endfunction

  function automatic cmd_t ctl(logic [1:0] m);
    cmd_t c;
    c = noise_cmd();
    c.mode = m;
    return c;
  endfunction

  function automatic entry_t rand_event(bit allow_stop);
    entry_t e;
    cmd_t   c;
    int     pick;
    int     k;
    c = noise_cmd();
    e = c.ev;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      e.kind = KIND_PAL;
      if ($urandom_range(0, 9) == 0) e.count = 9'($urandom_range(257, 511));
      else e.count = 9'($urandom_range(0, 256));
      e.fade_on = 1'($urandom_range(0, 1));
      e.fade_value = 8'($urandom_range(0, 64));
      if ($urandom_range(0, 7) == 0) e.fade_step = 8'($urandom_range(192, 255));
      else e.fade_step = 8'($urandom_range(8, 64));
    end else if (pick < 55) begin
      e.kind = KIND_PAN;
      e.pan_adjust = 16'($urandom_range(1, 65535));
      k = $urandom_range(0, 4);
      if ($urandom_range(0, 9) == 0) begin
        e.pan_adjust = 16'd0;
        k = 0;
      end
      e.pan_end = e.word + 16'(k * e.pan_adjust);
    end else if (pick < 75) begin
      e.kind = KIND_WAIT;
      e.word = 16'($urandom_range(0, 3));
    end else if (pick < 90) begin
      e.kind = KIND_DONE;
      if ($urandom_range(0, 7) != 0) e.word = 16'($urandom_range(0, 3));
    end else if (pick < 95) begin
      e.kind = 3'($urandom_range(5, 7));
    end else if (allow_stop) begin
      e.kind = KIND_STOP;
    end else begin
      e.kind = KIND_WAIT;
      e.word = 16'd0;
    end
    return e;
  endfunction

  task automatic note_error(string what);
    err_count++;
    if (err_count <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic cmp(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) note_error($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  task automatic check_update();
    frame_res_t want;
    if (due_updates.size() == 0) begin
      note_error("result transaction with nothing pending");
    end else begin
      want = due_updates.pop_front();
      cmp("status", 16'(status_o), 16'(want.status));
      cmp("start_valid", 16'(start_valid_o), 16'(want.start_valid));
      cmp("start_address", start_address_o, want.start_address);
      cmp("pal_valid", 16'(pal_valid_o), 16'(want.pal_valid));
      cmp("out_slot", 16'(out_slot_o), 16'(want.slot));
      cmp("out_first", 16'(out_first_o), 16'(want.first));
      cmp("out_count", 16'(out_count_o), 16'(want.count));
      cmp("out_target", 16'(out_target_o), 16'(want.target));
      cmp("cap_on", 16'(cap_on_o), 16'(want.cap_on));
      cmp("cap_level", 16'(cap_level_o), 16'(want.cap_level));
      cmp("chain_pulse", 16'(chain_pulse_o), 16'(want.chain_pulse));
      cmp("queue_idle", 16'(queue_idle_o), 16'(want.queue_idle));
    end
  endtask

  task automatic push_cmd(input cmd_t c, input bit typed, input frame_res_t want);
    frame_res_t r;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= c.mode;
    event_kind_i <= c.ev.kind;
    first_word_i <= c.ev.word;
    pan_end_i <= c.ev.pan_end;
    pan_adjust_i <= c.ev.pan_adjust;
    pal_slot_i <= c.ev.slot;
    pal_first_i <= c.ev.first;
    pal_count_i <= c.ev.count;
    pal_target_i <= c.ev.target;
    fade_on_i <= c.ev.fade_on;
    fade_value_i <= c.ev.fade_value;
    fade_step_i <= c.ev.fade_step;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = display_update(c);
    due_updates.push_back(typed ? want : r);
    xfer_count++;
    if (c.mode == MODE_TICK) n_ticks++;
    if (r.pal_valid) n_pal++;
    if (r.cap_on) n_fade++;
    if (r.start_valid) n_pan++;
    if (r.chain_pulse) n_pulse++;
    if (r.status) n_drop++;
  endtask

  task automatic send(input cmd_t c);
    push_cmd(c, 1'b0, '0);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_updates.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_chain_step(logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_CHAIN_STEP;
    pwdata <= {16'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    step_reg = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {16'h0, v}) note_error($sformatf("chain_step read %0h, wrote %0h", prdata, v));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_program();
    entry_t e;
    if (tail_idx > 48) send(ctl(MODE_FLUSH));
    repeat ($urandom_range(1, 6)) send({MODE_ENQ, rand_event(1'b0)});
    if ($urandom_range(0, 1) == 1) begin
      e = rand_event(1'b0);
      e.kind = KIND_STOP;
      send({MODE_ENQ, e});
    end
    repeat ($urandom_range(1, 8))
      send(($urandom_range(0, 9) == 0) ? ctl(MODE_HURRY) : ctl(MODE_TICK));
  endtask

  // receiver: stall bursts, long hold, result check
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) check_update();
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
      n_holds++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_burst > 0) begin
      stall_burst--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_burst = $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results pending", QUIET_LIMIT,
               due_updates.size());
      $display("tb_vsync_display_event_sequencer: done, errors");
      $finish;
    end
  end

  initial begin
    cmd_t        plan [22];
    bit          plan_typed [22];
    frame_res_t  plan_want [22];
    logic [15:0] step_plan [5];
    entry_t      e;
    int          goal;

    plan[0]  = ctl(MODE_TICK);
    plan[1]  = ctl(MODE_HURRY);
    plan[2]  = {MODE_ENQ, make_ev(KIND_PAL, 16'h0, 16'h0, 16'h0, 3'd7, 8'hFF, 9'd511, 8'hFF,
                                  1'b0, 8'h0, 8'h0)};
    plan[3]  = {MODE_ENQ, make_ev(KIND_PAN, 16'hFFFF, 16'h0001, 16'h0002, 3'd0, 8'h0, 9'd0,
                                  8'h0, 1'b0, 8'h0, 8'h0)};
    plan[4]  = {MODE_ENQ, make_ev(KIND_WAIT, 16'd2, 16'h0, 16'h0, 3'd0, 8'h0, 9'd0, 8'h0,
                                  1'b0, 8'h0, 8'h0)};
    plan[5]  = ctl(MODE_HURRY);
    plan[6]  = ctl(MODE_TICK);
    plan[7]  = ctl(MODE_HURRY);
    plan[8]  = {MODE_ENQ, make_ev(KIND_DONE, 16'h0003, 16'h0, 16'h0, 3'd0, 8'h0, 9'd0, 8'h0,
                                  1'b0, 8'h0, 8'h0)};
    plan[9]  = {MODE_ENQ, make_ev(KIND_PAL, 16'h0, 16'h0, 16'h0, 3'd0, 8'h0, 9'd0, 8'h0,
                                  1'b1, 8'd0, 8'd32)};
    plan[10] = {MODE_ENQ, make_ev(KIND_BOGUS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 8'hFF,
                                  9'h1FF, 8'hFF, 1'b1, 8'hFF, 8'hFF)};
    plan[11] = {MODE_ENQ, make_ev(KIND_STOP, 16'h0, 16'h0, 16'h0, 3'd0, 8'h0, 9'd0, 8'h0,
                                  1'b0, 8'h0, 8'h0)};
    for (int i = 12; i <= 16; i++) plan[i] = ctl(MODE_TICK);
    plan[17] = {MODE_ENQ, make_ev(KIND_WAIT, 16'hFFFF, 16'h0, 16'h0, 3'd0, 8'h0, 9'd0, 8'h0,
                                  1'b0, 8'h0, 8'h0)};
    plan[18] = ctl(MODE_HURRY);
    plan[19] = ctl(MODE_TICK);
    plan[20] = {MODE_ENQ, make_ev(KIND_DONE, 16'h0, 16'h0, 16'h0, 3'd0, 8'h0, 9'd0, 8'h0,
                                  1'b0, 8'h0, 8'h0)};
    plan[21] = ctl(MODE_FLUSH);
    foreach (plan_typed[i]) plan_typed[i] = 1'b0;
    foreach (plan_want[i]) plan_want[i] = '0;
    plan_want[0] = quiet_res(1'b1, 1'b0);
    plan_want[1] = quiet_res(1'b1, 1'b0);
    plan_want[21] = quiet_res(1'b1, 1'b0);
    foreach (plan_want[i])
      if (i inside {2, 3, 4, 5, 8, 9, 10, 11, 17, 20}) plan_want[i] = quiet_res(1'b0, 1'b0);
    foreach (plan_typed[i]) plan_typed[i] = (i inside {0, 1, 2, 3, 4, 5, 8, 9, 10, 11, 17, 20, 21});
    step_plan = '{16'd1, 16'($urandom), 16'h8000, 16'($urandom), 16'hFFFF};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_chain_step(16'hFFFF);
    foreach (plan[i]) push_cmd(plan[i], plan_typed[i], plan_want[i]);

    // fill the queue to the top, then overflow it
    settle();
    set_chain_step(16'h0000);
    for (int i = 0; i < DEPTH; i++) begin
      e = rand_event(1'b0);
      if (e.kind == KIND_WAIT || e.kind == KIND_DONE) e.kind = KIND_BOGUS;
      send({MODE_ENQ, e});
    end
    repeat (2) push_cmd({MODE_ENQ, rand_event(1'b0)}, 1'b1, quiet_res(1'b0, 1'b1));
    repeat (3) send(ctl(MODE_TICK));
    send(ctl(MODE_FLUSH));

    for (int p = 0; p < 5; p++) begin
      settle();
      set_chain_step(step_plan[p]);
      idle_on = (p != 4);
      if (p == 0) hold_req = 1'b1;
      goal = xfer_count + PHASE_ITEMS;
      while (xfer_count < goal) begin
        if ($urandom_range(0, 99) < 15) send(noise_cmd());
        else run_program();
      end
    end

    settle();
    repeat (80) @(posedge clk_i);
    $display("covered %0d transactions, %0d ticks, %0d dropped enqueues, %0d long holds",
             xfer_count, n_ticks, n_drop, n_holds);
    $display("jobs seen: %0d palette (%0d faded), %0d pan starts, %0d chain pulses",
             n_pal, n_fade, n_pan, n_pulse);
    if (err_count == 0)
      $display("tb_vsync_display_event_sequencer: done, clean");
    else
      $display("tb_vsync_display_event_sequencer: done, errors");
    $finish;
  end

endmodule

/* files.f */
rtl/core/vdes_pkg.sv
rtl/core/vdes_queue_ram.sv
rtl/core/vdes_job_unit.sv
rtl/core/vsync_display_event_sequencer.sv
rtl/core/vdes_checker.sv
bench/tb_vsync_display_event_sequencer.sv
